// ----- design/run_length_glitch_filter_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef RUN_LENGTH_GLITCH_FILTER_UNIT_MACROS_SVH
`define RUN_LENGTH_GLITCH_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define RLGF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define RLGF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define RLGF_ASSERT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rlgf_pkg.sv -----
package rlgf_pkg;

  // Default time field width
  localparam int TIME_WIDTH_DEF = 48;

  // Reset value of the minimum kept run length
  localparam int MIN_WIDTH_RST = 1;

  // Result pair entries held in the output queue
  localparam int PAIR_DEPTH = 2;

  // Push request from the filter core to the output queue
  typedef struct packed {
    logic push;  // at least one result this item
    logic two;   // the item produced two results
  } rlgf_push_t;

endpackage

// ----- design/rlgf_in_if.sv -----
interface rlgf_in_if #(
  parameter int W = rlgf_pkg::TIME_WIDTH_DEF
);
  logic         valid;
  logic         ready;
  logic         level;
  logic [W-1:0] offset;
  logic [W-1:0] duration;
  logic         last;

  modport source (output valid, level, offset, duration, last, input ready);
  modport sink   (input valid, level, offset, duration, last, output ready);
endinterface

// ----- design/rlgf_out_if.sv -----
interface rlgf_out_if #(
  parameter int W = rlgf_pkg::TIME_WIDTH_DEF
);
  logic         valid;
  logic         ready;
  logic         pulse_level;
  logic [W-1:0] pulse_offset;
  logic [W-1:0] pulse_duration;
  logic         pulse_valid;
  logic         end_of_wave;

  modport source (output valid, pulse_level, pulse_offset, pulse_duration,
                  pulse_valid, end_of_wave, input ready);
  modport sink   (input valid, pulse_level, pulse_offset, pulse_duration,
                  pulse_valid, end_of_wave, output ready);
endinterface

// ----- design/rlgf_core.sv -----
// Run tracking and pending pulse state. Evaluates one item per go cycle and
// presents up to two results, packed as {level, offset, duration, valid, end}.
module rlgf_core #(
  parameter int W = rlgf_pkg::TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [W-1:0]         cfg_wdata,
  input  logic                 go,
  input  logic                 lvl,
  input  logic [W-1:0]         off,
  input  logic [W-1:0]         dur,
  input  logic                 last,
  output rlgf_pkg::rlgf_push_t push,
  output logic [2*W+2:0]       res0,
  output logic [2*W+2:0]       res1
);

  logic         min_r;
  logic [W-1:0] min_w_r;
  logic         first_r, first_nxt;
  logic         prev_r, prev_nxt;
  logic [W-1:0] run_r, run_nxt;
  logic         hp_r, hp_nxt;
  logic         plvl_r, plvl_nxt;
  logic [W-1:0] poff_r, poff_nxt;
  logic [W-1:0] pdur_r, pdur_nxt;

  logic         change, coal, qual, ext, emit_prev;
  logic [W:0]   s_run, s_ext;
  logic [W+1:0] s_fin;
  logic [W-1:0] run1, ext_dur, fin_dur, new_off;
  logic [W-1:0] hold_dur;

  // Minimum width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_w_r <= W'(rlgf_pkg::MIN_WIDTH_RST);
      min_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_w_r <= cfg_wdata;
      end
      min_r <= 1'b0;
    end
  end

  // Run closing decision
  assign change    = !first_r && (lvl != prev_r);
  assign coal      = hp_r && (prev_r == plvl_r);
  assign qual      = change && (run_r >= min_w_r) && !coal && !min_r;
  assign ext       = change && !qual && hp_r;
  assign emit_prev = qual && hp_r;

  // Saturating sums; chained saturating adds of nonnegative terms collapse to
  // one three-term add clipped once
  assign s_run   = {1'b0, (change ? '0 : run_r)} + {1'b0, dur};
  assign run1    = s_run[W] ? '1 : s_run[W-1:0];
  assign s_ext   = {1'b0, pdur_r} + {1'b0, run_r};
  assign ext_dur = s_ext[W] ? '1 : s_ext[W-1:0];
  assign s_fin   = {2'b00, (qual ? '0 : pdur_r)} + {2'b00, run_r} + {2'b00, dur};
  assign fin_dur = (s_fin[W+1:W] != 2'b00) ? '1 : s_fin[W-1:0];
  assign new_off = off - run_r;

  // Pending pulse after the run decision
  assign hold_dur = qual ? run_r : (ext ? ext_dur : pdur_r);

  always_comb begin
    first_nxt = first_r;
    prev_nxt  = prev_r;
    run_nxt   = run_r;
    hp_nxt    = hp_r;
    plvl_nxt  = plvl_r;
    poff_nxt  = poff_r;
    pdur_nxt  = pdur_r;
    if (go) begin
      if (last) begin
        first_nxt = 1'b1;
        prev_nxt  = 1'b0;
        run_nxt   = '0;
        hp_nxt    = 1'b0;
        plvl_nxt  = 1'b0;
        poff_nxt  = '0;
        pdur_nxt  = '0;
      end else begin
        first_nxt = 1'b0;
        prev_nxt  = lvl;
        run_nxt   = run1;
        hp_nxt    = hp_r | qual;
        plvl_nxt  = qual ? prev_r : plvl_r;
        poff_nxt  = qual ? new_off : poff_r;
        pdur_nxt  = hold_dur;
      end
    end
  end

  // Waveform state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      prev_r  <= 1'b0;
      run_r   <= '0;
      hp_r    <= 1'b0;
      plvl_r  <= 1'b0;
      poff_r  <= '0;
      pdur_r  <= '0;
    end else begin
      first_r <= first_nxt;
      prev_r  <= prev_nxt;
      run_r   <= run_nxt;
      hp_r    <= hp_nxt;
      plvl_r  <= plvl_nxt;
      poff_r  <= poff_nxt;
      pdur_r  <= pdur_nxt;
    end
  end

  // Results: the displaced pulse first, then the flushed one
  always_comb begin
    logic [2*W+2:0] fin;
    if (hp_r | qual) begin
      fin = {(qual ? prev_r : plvl_r), (qual ? new_off : poff_r), fin_dur, 1'b1, 1'b1};
    end else begin
      fin = {1'b0, {W{1'b0}}, {W{1'b0}}, 1'b0, 1'b1};
    end
    res1 = fin;
    res0 = emit_prev ? {plvl_r, poff_r, pdur_r, 1'b1, 1'b0} : fin;
  end

  assign push.push = go && (emit_prev || last);
  assign push.two  = emit_prev && last;

endmodule

// ----- design/rlgf_pair_fifo.sv -----
// Output queue of result pairs; each entry holds one or two results that
// leave one per transfer.
module rlgf_pair_fifo #(
  parameter int W = rlgf_pkg::TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rlgf_pkg::rlgf_push_t push,
  input  logic [2*W+2:0]       res0,
  input  logic [2*W+2:0]       res1,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2*W+2:0]       out_res
);

  localparam int DEPTH = rlgf_pkg::PAIR_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [2*W+2:0] e0_r [DEPTH];
  logic [2*W+2:0] e1_r [DEPTH];
  logic           two_r [DEPTH];
  logic [PW-1:0]  wr_r, rd_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           sub_r;
  logic           pop, retire, wr;

  assign out_valid = (cnt_r != '0);
  assign out_res   = sub_r ? e1_r[rd_r] : e0_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign retire    = pop && (sub_r || !two_r[rd_r]);
  assign can_push  = (cnt_r != CW'(DEPTH)) || retire;
  assign wr        = push.push && can_push;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !retire) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!wr && retire) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
      sub_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (retire) begin
        rd_r  <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
        sub_r <= 1'b0;
      end else if (pop) begin
        sub_r <= 1'b1;
      end
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (wr) begin
      e0_r[wr_r]  <= res0;
      e1_r[wr_r]  <= res1;
      two_r[wr_r] <= push.two;
    end
  end

endmodule

// ----- design/run_length_glitch_filter_unit.sv -----
// Flow: an input transfer loads the input register; the filter core then
// evaluates the item and pushes its results into the output queue, which
// offers them on out_ch. Throughput: one item per cycle while the output
// queue can accept a push. The output port moves one result per cycle while
// out_ch.ready is high, so an item with two results takes two transfers.
// Reset: synchronous, active low; clears the waveform state, empties the queue
// and sets min_width to 1.
module run_length_glitch_filter_unit #(
  parameter int TIME_WIDTH = rlgf_pkg::TIME_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  rlgf_in_if.sink         in_ch,
  rlgf_out_if.source      out_ch,
  input  logic            cfg_we,
  input  logic [TIME_WIDTH-1:0] cfg_wdata
);

  localparam int W = TIME_WIDTH;

  logic         s1_vld_r, s1_vld_nxt;
  logic         s1_lvl_r;
  logic [W-1:0] s1_off_r, s1_dur_r;
  logic         s1_last_r;
  logic         go, can_push, in_xfer;

  rlgf_pkg::rlgf_push_t push;
  logic [2*W+2:0] res0, res1, out_res;

  // Input register
  assign go           = s1_vld_r && can_push;
  assign in_ch.ready  = !s1_vld_r || go;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign s1_vld_nxt   = in_xfer ? 1'b1 : (go ? 1'b0 : s1_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_lvl_r  <= in_ch.level;
      s1_off_r  <= in_ch.offset;
      s1_dur_r  <= in_ch.duration;
      s1_last_r <= in_ch.last;
    end
  end

  rlgf_core #(.W(W)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .go        (go),
    .lvl       (s1_lvl_r),
    .off       (s1_off_r),
    .dur       (s1_dur_r),
    .last      (s1_last_r),
    .push      (push),
    .res0      (res0),
    .res1      (res1)
  );

  rlgf_pair_fifo #(.W(W)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // Unpack {level, offset, duration, valid, end}
  assign out_ch.pulse_level    = out_res[2*W+2];
  assign out_ch.pulse_offset   = out_res[2*W+1:W+2];
  assign out_ch.pulse_duration = out_res[W+1:2];
  assign out_ch.pulse_valid    = out_res[1];
  assign out_ch.end_of_wave    = out_res[0];

endmodule

// ----- design/rlgf_checker.sv -----
`include "run_length_glitch_filter_unit_macros.svh"

// Port-level checks on the result channel.
module rlgf_checker #(
  parameter int W = rlgf_pkg::TIME_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic         pulse_level,
  input logic [W-1:0] pulse_offset,
  input logic [W-1:0] pulse_duration,
  input logic         pulse_valid,
  input logic         end_of_wave
);

  // A stalled result stays offered
  `RLGF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload
  `RLGF_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(pulse_level) && $stable(pulse_offset) && $stable(pulse_duration) && $stable(pulse_valid) && $stable(end_of_wave), "stalled result changed")

  // The empty-waveform marker closes the waveform and carries zero fields
  `RLGF_ASSERT_NOW(a_empty_marker, clk, rst_n, out_valid && !pulse_valid, end_of_wave && !pulse_level && (pulse_offset == '0) && (pulse_duration == '0), "bad empty marker")

  // Out of reset the queue is empty and input is open
  `RLGF_ASSERT_RST(a_reset_clear, clk, !rst_n, !out_valid && in_ready, "not idle after reset")

endmodule

bind run_length_glitch_filter_unit rlgf_checker #(.W(TIME_WIDTH)) u_rlgf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .pulse_level    (out_ch.pulse_level),
  .pulse_offset   (out_ch.pulse_offset),
  .pulse_duration (out_ch.pulse_duration),
  .pulse_valid    (out_ch.pulse_valid),
  .end_of_wave    (out_ch.end_of_wave)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int TW = rlgf_pkg::TIME_WIDTH_DEF;
  localparam int HOLD_CYCLES = 300;

  typedef logic [TW-1:0] time_t;

  typedef struct packed {
    logic  level;
    time_t offset;
    time_t duration;
    logic  last;
  } sample_t;

  typedef struct packed {
    logic  level;
    time_t offset;
    time_t duration;
    logic  valid;
    logic  eow;
  } pulse_t;

  // Glitch filter predictor plus the queue of pulses still owed by the block
  class pulse_scoreboard;
    time_t  min_width;
    bit     first_item;
    bit     prev_level;
    time_t  run_len;
    bit     have_pend;
    bit     pend_level;
    time_t  pend_off;
    time_t  pend_dur;
    pulse_t pulses_due[$];
    int     errors;
    int     n_samples;
    int     n_pulses;
    int     n_empty;

    function new();
      min_width = time_t'(rlgf_pkg::MIN_WIDTH_RST);
      errors    = 0;
      n_samples = 0;
      n_pulses  = 0;
      n_empty   = 0;
      clear_wave();
    endfunction

    function void clear_wave();
      first_item = 1'b1;
      prev_level = 1'b0;
      run_len    = '0;
      have_pend  = 1'b0;
      pend_level = 1'b0;
      pend_off   = '0;
      pend_dur   = '0;
    endfunction

    function time_t sat_add(time_t a, time_t b);
      logic [TW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TW] ? '1 : s[TW-1:0];
    endfunction

    function int due_count();
      return pulses_due.size();
    endfunction

    // Accepted sample: advance the filter and queue whatever pulses it releases
    function void note_sample(sample_t s);
      bit merge;
      n_samples++;
      if (!first_item && s.level != prev_level) begin
        // run just closed: new pulse, or fold into the pending one
        merge = have_pend && (prev_level == pend_level);
        if (run_len >= min_width && !merge) begin
          if (have_pend)
            pulses_due.push_back('{pend_level, pend_off, pend_dur, 1'b1, 1'b0});
          have_pend  = 1'b1;
          pend_level = prev_level;
          pend_off   = s.offset - run_len;
          pend_dur   = run_len;
        end else if (have_pend) begin
          pend_dur = sat_add(pend_dur, run_len);
        end
        run_len = '0;
      end
      run_len    = sat_add(run_len, s.duration);
      prev_level = s.level;
      first_item = 1'b0;

      // end of waveform: flush pending pulse or give the empty marker
      if (s.last) begin
        if (have_pend) begin
          pend_dur = sat_add(pend_dur, run_len);
          pulses_due.push_back('{pend_level, pend_off, pend_dur, 1'b1, 1'b1});
        end else begin
          pulses_due.push_back('{1'b0, time_t'(0), time_t'(0), 1'b0, 1'b1});
        end
        clear_wave();
      end
    endfunction

    // Result transfer: compare against the oldest owed pulse
    function void check_pulse(pulse_t got);
      pulse_t want;
      if (pulses_due.size() == 0) begin
        $error("unexpected result: level %0b offset %0h duration %0h valid %0b end %0b",
               got.level, got.offset, got.duration, got.valid, got.eow);
        errors++;
        return;
      end
      want = pulses_due.pop_front();
      n_pulses++;
      if (!want.valid)
        n_empty++;
      if (got.level !== want.level) begin
        $error("pulse_level: expected %0h, got %0h", want.level, got.level);
        errors++;
      end
      if (got.offset !== want.offset) begin
        $error("pulse_offset: expected %0h, got %0h", want.offset, got.offset);
        errors++;
      end
      if (got.duration !== want.duration) begin
        $error("pulse_duration: expected %0h, got %0h", want.duration, got.duration);
        errors++;
      end
      if (got.valid !== want.valid) begin
        $error("pulse_valid: expected %0h, got %0h", want.valid, got.valid);
        errors++;
      end
      if (got.eow !== want.eow) begin
        $error("end_of_wave: expected %0h, got %0h", want.eow, got.eow);
        errors++;
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n;
  logic  cfg_we;
  time_t cfg_wdata;

  rlgf_in_if  #(.W(TW)) in_ch ();
  rlgf_out_if #(.W(TW)) out_ch ();

  run_length_glitch_filter_unit #(.TIME_WIDTH(TW)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pulse_scoreboard sb = new();

  bit    in_quiet   = 1'b0;
  bit    out_quiet  = 1'b0;
  bit    stall_req  = 1'b0;
  time_t cur_mw     = time_t'(rlgf_pkg::MIN_WIDTH_RST);
  int    items_sent = 0;
  int    n_settings = 1;

  always #5 clk = ~clk;

  // Watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Monitor both channels on the clock edge
  always @(posedge clk) begin
    sample_t s;
    pulse_t  p;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        s = '{in_ch.level, in_ch.offset, in_ch.duration, in_ch.last};
        sb.note_sample(s);
      end
      if (out_ch.valid && out_ch.ready) begin
        p = '{out_ch.pulse_level, out_ch.pulse_offset, out_ch.pulse_duration,
              out_ch.pulse_valid, out_ch.end_of_wave};
        sb.check_pulse(p);
      end
    end
  end

  // Result side: random stalls, quiet stretches, and one long hold-off
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (stall_req) begin
        stall     = HOLD_CYCLES;
        stall_req = 1'b0;
      end else begin
        stall = out_quiet ? 0 : $urandom_range(0, 5);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic time_t rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TW-1:0];
  endfunction

  // Durations spread around the current threshold, with some extremes
  function automatic time_t pick_dur(time_t mw);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)
      return '0;
    if (r < 8)
      return '1;
    if (r < 16)
      return rand48();
    if (mw > 64)
      return mw + time_t'($urandom_range(0, 6)) - time_t'(3);
    return time_t'($urandom_range(0, int'(mw) * 2 + 2));
  endfunction

  function automatic time_t phase_width(int ph);
    case (ph)
      0:       return '0;
      1:       return '1;
      2:       return time_t'(1);
      3:       return time_t'(3);
      4:       return time_t'(8);
      5:       return time_t'($urandom_range(1, 40));
      6:       return rand48();
      default: return time_t'(2);
    endcase
  endfunction

  // One sample transfer on the input channel, after a random gap
  task automatic send_sample(input sample_t s);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.level    <= s.level;
    in_ch.offset   <= s.offset;
    in_ch.duration <= s.duration;
    in_ch.last     <= s.last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send(input logic lvl, input time_t off, input time_t dur, input logic lst);
    send_sample('{lvl, off, dur, lst});
  endtask

  // Well-formed waveform: contiguous samples, occasional offset jumps
  task automatic send_wave(input int len);
    time_t   t;
    logic    lvl;
    sample_t s;
    t   = ($urandom_range(0, 9) == 0) ? rand48() : time_t'($urandom_range(0, 1000));
    lvl = logic'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 2) != 0)
        lvl = ~lvl;
      s.level    = lvl;
      s.duration = pick_dur(cur_mw);
      s.offset   = ($urandom_range(0, 19) == 0) ? rand48() : t;
      s.last     = (i == len - 1);
      t          = t + s.duration;
      send_sample(s);
    end
  endtask

  // Threshold write once the block has drained
  task automatic write_min_width(input time_t v);
    in_ch.valid <= 1'b0;
    // let the monitor log the final transfer before checking for owed results
    @(posedge clk);
    while (sb.due_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sb.min_width  = v;
    cur_mw        = v;
    n_settings++;
  endtask

  // Stimulus
  initial begin
    int goal;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.level    <= 1'b0;
    in_ch.offset   <= '0;
    in_ch.duration <= '0;
    in_ch.last     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // lone last sample: empty waveform marker
    send(1'b1, '0, '0, 1'b1);
    // two pulses, second qualifies on the final sample
    send(1'b0, 48'd0, 48'd5, 1'b0);
    send(1'b1, 48'd5, 48'd5, 1'b0);
    send(1'b0, 48'd10, 48'd5, 1'b1);
    // zero-length glitch folds into the pending pulse
    send(1'b0, 48'd0, 48'd10, 1'b0);
    send(1'b1, 48'd10, 48'd0, 1'b0);
    send(1'b0, 48'd10, 48'd10, 1'b1);
    // short runs before any pulse are dropped
    send(1'b1, 48'd0, 48'd0, 1'b0);
    send(1'b0, 48'd0, 48'd0, 1'b0);
    send(1'b1, 48'd0, 48'd3, 1'b0);
    send(1'b0, 48'd3, 48'd2, 1'b1);
    // saturating runs at full-scale offsets
    send(1'b1, '1, '1, 1'b0);
    send(1'b1, '1, '1, 1'b0);
    send(1'b0, '1, '1, 1'b0);
    send(1'b1, '0, 48'd1, 1'b1);
    // long run with the pending level merges instead of emitting
    send(1'b1, 48'd100, 48'd4, 1'b0);
    send(1'b0, 48'd104, 48'd0, 1'b0);
    send(1'b1, 48'd104, 48'd6, 1'b0);
    send(1'b0, 48'd110, 48'd3, 1'b1);
    // pulse start wraps below zero
    send(1'b0, 48'd5, 48'd20, 1'b0);
    send(1'b1, 48'd3, 48'd2, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      write_min_width(phase_width(ph));
      if (ph == 0) begin
        // zero threshold: zero-length runs become pulses
        send(1'b0, '0, '0, 1'b0);
        send(1'b1, '0, '0, 1'b0);
        send(1'b0, '0, '0, 1'b1);
      end else if (ph == 1) begin
        // full-scale threshold: only a saturated run qualifies
        send(1'b0, '0, '1, 1'b0);
        send(1'b1, '1, '0, 1'b0);
        send(1'b0, '1, 48'd5, 1'b1);
      end else if (ph == 7) begin
        // back-to-back short waveforms against a held-off result port
        in_quiet  = 1'b1;
        stall_req = 1'b1;
        for (int i = 0; i < 30; i++)
          send_wave($urandom_range(1, 2));
        in_quiet = 1'b0;
      end

      goal = 21 + (ph + 1) * 185;
      while (items_sent < goal) begin
        in_quiet  = ($urandom_range(0, 5) == 0);
        out_quiet = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 4) == 0)
          send_sample('{logic'($urandom_range(0, 1)), rand48(), rand48(),
                        logic'($urandom_range(0, 3) == 0)});
        else
          send_wave(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12));
      end
      // close any open waveform before the next threshold
      send(logic'($urandom_range(0, 1)), rand48(), pick_dur(cur_mw), 1'b1);
      in_quiet  = 1'b0;
      out_quiet = 1'b0;
    end

    // drain and let the pipeline settle
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_count() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d samples and %0d results (%0d empty-waveform markers)",
             sb.n_samples, sb.n_pulses, sb.n_empty);
    $display("across %0d min_width settings, including zero, full scale and a long output stall",
             n_settings);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
